// File: src/twao_pkg.sv
// Package for the three-wheel arc odometry block: state codes, register indexes,
// fixed-point constants, the arctangent table and small rounding/saturation helpers.
// No dependencies.
`default_nettype none

package twao_pkg;

  // Default number of CORDIC iterations
  localparam int CORDIC_STEPS_DEF = 24;

  // Serial unit lengths
  localparam int MUL_BITS = 32;
  localparam int DIV_BITS = 64;

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE_ARM   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE_SCALE   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE_SCALE = 8'd3;

  // Register reset values
  localparam logic [19:0] TRACK_WIDTH_RST = 20'd15360;
  localparam logic [31:0] SCALE_RST       = 32'd4096;

  // Fixed-point constants, angles and sin/cos in Q30
  localparam logic signed [35:0] Q30_ONE     = 36'sd1073741824;
  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [35:0] GAIN_Q30    = 36'sd652032874;
  localparam logic signed [33:0] OFF_LIMIT   = 34'sd4294967295;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE, ST_LD, ST_RD, ST_MD, ST_HD, ST_DA, ST_CR, ST_CI, ST_SC,
    ST_LX1, ST_LX2, ST_LY1, ST_LY2, ST_RX1, ST_RX2, ST_RY1, ST_RY2, ST_FIN
  } twao_state_t;

  // atan(2^-i) in Q30
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0:  return 30'd843314857;
      5'd1:  return 30'd497837829;
      5'd2:  return 30'd263043837;
      5'd3:  return 30'd133525159;
      5'd4:  return 30'd67021687;
      5'd5:  return 30'd33543516;
      5'd6:  return 30'd16775851;
      5'd7:  return 30'd8388437;
      5'd8:  return 30'd4194283;
      5'd9:  return 30'd2097149;
      5'd30: return 30'd1;
      5'd31: return 30'd1;
      default: return 30'(30'd1 << (5'd30 - i));
    endcase
  endfunction

  // Magnitude of a signed value
  function automatic logic [65:0] mag_of(input logic signed [65:0] v);
    return v[65] ? 66'(-v) : 66'(v);
  endfunction

  // Shift right by sh with rounding half away from zero
  function automatic logic signed [65:0] rnd_shr(input logic signed [65:0] v,
                                                 input int unsigned sh);
    logic [65:0] m;
    logic [65:0] q;
    m = mag_of(v);
    q = (m + (66'd1 << (sh - 1))) >> sh;
    return v[65] ? -$signed(q) : $signed(q);
  endfunction

  // Saturate to 32-bit two's complement
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Clamp to +-1.0 in Q30
  function automatic logic signed [31:0] clamp_q30(input logic signed [35:0] v);
    if (v > Q30_ONE) return 32'sd1073741824;
    if (v < -Q30_ONE) return -32'sd1073741824;
    return v[31:0];
  endfunction

  // Clamp a local offset to +-(2^32 - 1)
  function automatic logic signed [33:0] clamp_off(input logic signed [65:0] v);
    if (v > 66'(OFF_LIMIT)) return OFF_LIMIT;
    if (v < -66'(OFF_LIMIT)) return -OFF_LIMIT;
    return v[33:0];
  endfunction

endpackage

`default_nettype wire

// File: src/three_wheel_arc_odometry.sv
// Top level of the three-wheel arc odometry block: sequencer, bit-serial multiplier,
// restoring divider and CORDIC rotator. Depends on twao_pkg.
`default_nettype none

// Takes one transfer of three absolute encoder counts and returns the updated pose
// (x, y in 1/1024 inch, heading in 2^-24 rad), saturated. One sample is worked at a
// time by a sequencer around three shared serial units: a 32-step shift-add
// multiplier, a 64-step restoring divider and a CORDIC of CORDIC_STEPS iterations.
// A sample with a heading change runs the CORDIC twice, a straight sample once.
// The result sits in an output register, so the next sample is taken while the
// last result still waits. Configuration writes are meant for idle periods only.
module three_wheel_arc_odometry import twao_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [31:0]          in_left_count,
  input  logic signed [31:0]          in_right_count,
  input  logic signed [31:0]          in_middle_count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [31:0]          out_pose_x_out,
  output logic signed [31:0]          out_pose_y_out,
  output logic signed [31:0]          out_heading_out
);

  localparam int CW = $clog2(CORDIC_STEPS);
  localparam logic [CW-1:0] CI_LAST  = CW'(CORDIC_STEPS - 1);
  localparam logic [4:0]    MUL_LAST = 5'(MUL_BITS - 1);
  localparam logic [5:0]    DIV_LAST = 6'(DIV_BITS - 1);

  // Configuration and pose state
  logic        [19:0] tw_r;
  logic signed [20:0] arm_r;
  logic        [31:0] ss_r, ms_r;
  logic signed [31:0] pl_r, pr_r, pm_r, px_r, py_r, hd_r;

  // Sequencer
  twao_state_t state_r, state_nxt;
  logic        first_r, ph_r, fin_go;

  // Working registers
  logic signed [31:0] cl_r, cr_r, cm_r, nl_r, nr_r, nm_r, na_r;
  logic signed [32:0] da_r;
  logic signed [31:0] s1_r, sa_r, ca_r, sc_r;
  logic signed [33:0] lx_r, ly_r;
  logic signed [65:0] acc_r;
  logic               out_valid_r;
  logic signed [31:0] ox_r, oy_r, oh_r;

  // Multiplier
  logic        [63:0] mu_a_r, mu_p_r;
  logic        [31:0] mu_b_r;
  logic               mu_neg_r, mu_busy_r, mu_done_r;
  logic        [4:0]  mu_cnt_r;
  logic               mul_go, mul_neg;
  logic        [31:0] mul_a, mul_b;
  logic signed [65:0] mul_res;

  // Divider
  logic        [33:0] dv_rem_r, dv_den_r;
  logic        [63:0] dv_quo_r;
  logic        [5:0]  dv_cnt_r;
  logic               dv_busy_r, dv_done_r;
  logic               div_go;
  logic        [63:0] div_num;
  logic        [33:0] div_den;
  logic        [34:0] dv_try, dv_dif;
  logic               dv_ge;

  // CORDIC
  logic signed [35:0] cx_r, cy_r, cz_r, cx_nxt, cy_nxt, cz_nxt, csx, csy, cat;
  logic        [CW-1:0] ci_r;
  logic               flip_r;
  logic signed [31:0] cs_out, cc_out;

  // Derived values
  wire logic [19:0]   wv = (tw_r == 20'd0) ? 20'd1 : tw_r;
  logic signed [32:0] dl, dr, dm, ndiff, dmean;
  logic signed [33:0] dsum, hsum, cang;
  logic signed [21:0] arm2;
  logic signed [40:0] t_ang;
  logic signed [35:0] rem_s, rr, r2, z0;
  logic               fl0;
  logic signed [65:0] qs, hsg, sgq;
  logic signed [31:0] hq, scq;
  logic        [31:0] sc_mag;

  assign dl    = 33'(nl_r) - 33'(pl_r);
  assign dr    = 33'(nr_r) - 33'(pr_r);
  assign dm    = 33'(nm_r) - 33'(pm_r);
  assign ndiff = 33'(nl_r) - 33'(nr_r);
  assign dsum  = 34'(dl) + 34'(dr);
  assign dmean = 33'(dsum >>> 1);
  assign hsum  = 34'(hd_r) + 34'(na_r);
  assign arm2  = $signed({arm_r, 1'b0});
  assign cang  = ph_r ? hsum : 34'(da_r);
  assign t_ang = (41'(cang) <<< 5) + 41'(PI_Q30);

  // Angle reduction into [-pi/2, pi/2] from the divider remainder
  always_comb begin
    rem_s = $signed({2'b00, dv_rem_r});
    rr    = (t_ang[40] && dv_rem_r != 34'd0) ? TWO_PI_Q30 - rem_s : rem_s;
    r2    = rr - PI_Q30;
    fl0   = 1'b1;
    if (r2 > HALF_PI_Q30) begin
      z0 = PI_Q30 - r2;
    end else if (r2 < -HALF_PI_Q30) begin
      z0 = -PI_Q30 - r2;
    end else begin
      z0  = r2;
      fl0 = 1'b0;
    end
  end

  // Signed quotient forms
  always_comb begin
    qs     = $signed({2'b00, dv_quo_r});
    hsg    = ndiff[32] ? -qs : qs;
    hq     = sat32(hsg);
    sc_mag = (dv_quo_r > 64'd1073741824) ? 32'd1073741824 : dv_quo_r[31:0];
    sgq    = (s1_r[31] ^ da_r[32]) ? -66'($signed({1'b0, sc_mag})) :
                                     66'($signed({1'b0, sc_mag}));
    scq    = sgq[31:0];
  end

  // CORDIC iteration
  always_comb begin
    csx = cy_r >>> ci_r;
    csy = cx_r >>> ci_r;
    cat = $signed({6'b0, atan_q30(5'(ci_r))});
    if (!cz_r[35]) begin
      cx_nxt = cx_r - csx;
      cy_nxt = cy_r + csy;
      cz_nxt = cz_r - cat;
    end else begin
      cx_nxt = cx_r + csx;
      cy_nxt = cy_r - csy;
      cz_nxt = cz_r + cat;
    end
    cs_out = clamp_q30(cy_nxt);
    cc_out = clamp_q30(flip_r ? -cx_nxt : cx_nxt);
  end

  assign mul_res = mu_neg_r ? -$signed(66'(mu_p_r)) : $signed(66'(mu_p_r));

  // Divider step
  assign dv_try = {dv_rem_r, dv_quo_r[63]};
  assign dv_dif = dv_try - {1'b0, dv_den_r};
  assign dv_ge  = dv_try >= {1'b0, dv_den_r};

  assign fin_go = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_LD;
      ST_LD:   if (mu_done_r) state_nxt = ST_RD;
      ST_RD:   if (mu_done_r) state_nxt = ST_MD;
      ST_MD:   if (mu_done_r) state_nxt = ST_HD;
      ST_HD:   if (dv_done_r) state_nxt = ST_DA;
      ST_DA:   state_nxt = ST_CR;
      ST_CR:   if (dv_done_r) state_nxt = ST_CI;
      ST_CI:   if (ci_r == CI_LAST) state_nxt = ph_r ? ST_RX1 : ST_SC;
      ST_SC:   if (dv_done_r) state_nxt = ST_LX1;
      ST_LX1:  if (mu_done_r) state_nxt = ST_LX2;
      ST_LX2:  if (mu_done_r) state_nxt = ST_LY1;
      ST_LY1:  if (mu_done_r) state_nxt = ST_LY2;
      ST_LY2:  if (mu_done_r) state_nxt = ST_CR;
      ST_RX1:  if (mu_done_r) state_nxt = ST_RX2;
      ST_RX2:  if (mu_done_r) state_nxt = ST_RY1;
      ST_RY1:  if (mu_done_r) state_nxt = ST_RY2;
      ST_RY2:  if (mu_done_r) state_nxt = ST_FIN;
      ST_FIN:  if (fin_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Unit launches and operand selection
  always_comb begin
    mul_go  = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    div_go  = 1'b0;
    div_num = '0;
    div_den = '0;
    unique case (state_r)
      ST_LD: begin
        mul_go = first_r; mul_a = 32'(mag_of(66'(cl_r))); mul_b = ss_r;
        mul_neg = cl_r[31];
      end
      ST_RD: begin
        mul_go = first_r; mul_a = 32'(mag_of(66'(cr_r))); mul_b = ss_r;
        mul_neg = cr_r[31];
      end
      ST_MD: begin
        mul_go = first_r; mul_a = 32'(mag_of(66'(cm_r))); mul_b = ms_r;
        mul_neg = cm_r[31];
      end
      ST_HD: begin
        div_go  = first_r;
        div_num = 64'(mag_of(66'(ndiff)) << 24) + 64'(wv >> 1);
        div_den = 34'(wv);
      end
      ST_CR: begin
        div_go  = first_r;
        div_num = 64'(mag_of(66'(t_ang)));
        div_den = 34'(TWO_PI_Q30);
      end
      ST_SC: begin
        div_go  = first_r;
        div_num = 64'(mag_of(66'(s1_r)) << 25) + 64'(mag_of(66'(da_r)) >> 1);
        div_den = 34'(mag_of(66'(da_r)));
      end
      ST_LX1: begin
        mul_go = first_r; mul_a = 32'(mag_of(66'(dm))); mul_b = 32'(mag_of(66'(sc_r)));
        mul_neg = dm[32] ^ sc_r[31];
      end
      ST_LX2: begin
        mul_go = first_r; mul_a = 32'(mag_of(66'(arm2)));
        mul_b = 32'(mag_of(66'(s1_r))); mul_neg = arm2[21] ^ s1_r[31];
      end
      ST_LY1: begin
        mul_go = first_r; mul_a = 32'(mag_of(66'(dmean)));
        mul_b = 32'(mag_of(66'(sc_r))); mul_neg = dmean[32] ^ sc_r[31];
      end
      ST_LY2: begin
        mul_go = first_r; mul_a = 32'(wv); mul_b = 32'(mag_of(66'(s1_r)));
        mul_neg = s1_r[31];
      end
      ST_RX1: begin
        mul_go = first_r; mul_a = 32'(mag_of(66'(lx_r))); mul_b = 32'(mag_of(66'(ca_r)));
        mul_neg = lx_r[33] ^ ca_r[31];
      end
      ST_RX2: begin
        mul_go = first_r; mul_a = 32'(mag_of(66'(ly_r))); mul_b = 32'(mag_of(66'(sa_r)));
        mul_neg = ly_r[33] ^ sa_r[31];
      end
      ST_RY1: begin
        mul_go = first_r; mul_a = 32'(mag_of(66'(ly_r))); mul_b = 32'(mag_of(66'(ca_r)));
        mul_neg = ly_r[33] ^ ca_r[31];
      end
      ST_RY2: begin
        mul_go = first_r; mul_a = 32'(mag_of(66'(lx_r))); mul_b = 32'(mag_of(66'(sa_r)));
        mul_neg = !(lx_r[33] ^ sa_r[31]);
      end
      default: ;
    endcase
  end

  // Control, configuration and pose state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      first_r     <= 1'b0;
      ph_r        <= 1'b0;
      mu_busy_r   <= 1'b0;
      mu_done_r   <= 1'b0;
      mu_cnt_r    <= '0;
      dv_busy_r   <= 1'b0;
      dv_done_r   <= 1'b0;
      dv_cnt_r    <= '0;
      out_valid_r <= 1'b0;
      tw_r        <= TRACK_WIDTH_RST;
      arm_r       <= '0;
      ss_r        <= SCALE_RST;
      ms_r        <= SCALE_RST;
      pl_r        <= '0;
      pr_r        <= '0;
      pm_r        <= '0;
      px_r        <= '0;
      py_r        <= '0;
      hd_r        <= '0;
    end else begin
      state_r <= state_nxt;
      first_r <= (state_nxt != state_r);

      // register writes
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TRACK_WIDTH:  tw_r  <= cfg_data[19:0];
          CFG_MIDDLE_ARM:   arm_r <= cfg_data[20:0];
          CFG_SIDE_SCALE:   ss_r  <= cfg_data;
          CFG_MIDDLE_SCALE: ms_r  <= cfg_data;
          default: ;
        endcase
      end

      // multiplier sequencing
      if (mul_go) begin
        mu_busy_r <= 1'b1;
        mu_cnt_r  <= '0;
      end else if (mu_busy_r) begin
        mu_cnt_r <= mu_cnt_r + 5'd1;
        if (mu_cnt_r == MUL_LAST) mu_busy_r <= 1'b0;
      end
      mu_done_r <= mu_busy_r && (mu_cnt_r == MUL_LAST);

      // divider sequencing
      if (div_go) begin
        dv_busy_r <= 1'b1;
        dv_cnt_r  <= '0;
      end else if (dv_busy_r) begin
        dv_cnt_r <= dv_cnt_r + 6'd1;
        if (dv_cnt_r == DIV_LAST) dv_busy_r <= 1'b0;
      end
      dv_done_r <= dv_busy_r && (dv_cnt_r == DIV_LAST);

      // straight or arc path
      if (state_r == ST_DA) ph_r <= (da_r == 33'sd0);
      if (state_r == ST_LY2 && mu_done_r) ph_r <= 1'b1;

      // position update
      if (state_r == ST_RX2 && mu_done_r)
        px_r <= sat32(66'(px_r) + rnd_shr(acc_r + mul_res, 30));
      if (state_r == ST_RY2 && mu_done_r)
        py_r <= sat32(66'(py_r) + rnd_shr(acc_r + mul_res, 30));

      // commit and hand over the result
      if (fin_go) begin
        pl_r        <= nl_r;
        pr_r        <= nr_r;
        pm_r        <= nm_r;
        hd_r        <= na_r;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    // multiplier: one multiplier bit per cycle
    if (mul_go) begin
      mu_a_r   <= {32'd0, mul_a};
      mu_b_r   <= mul_b;
      mu_p_r   <= '0;
      mu_neg_r <= mul_neg;
    end else if (mu_busy_r) begin
      mu_p_r <= mu_p_r + (mu_b_r[0] ? mu_a_r : 64'd0);
      mu_a_r <= mu_a_r << 1;
      mu_b_r <= mu_b_r >> 1;
    end

    // divider: one quotient bit per cycle
    if (div_go) begin
      dv_rem_r <= '0;
      dv_quo_r <= div_num;
      dv_den_r <= div_den;
    end else if (dv_busy_r) begin
      dv_rem_r <= dv_ge ? dv_dif[33:0] : dv_try[33:0];
      dv_quo_r <= {dv_quo_r[62:0], dv_ge};
    end

    if (fin_go) begin
      ox_r <= px_r;
      oy_r <= py_r;
      oh_r <= na_r;
    end

    case (state_r)
      ST_IDLE: if (in_valid) begin
        cl_r <= in_left_count;
        cr_r <= in_right_count;
        cm_r <= in_middle_count;
      end
      ST_LD: if (mu_done_r) nl_r <= sat32(rnd_shr(mul_res, 14));
      ST_RD: if (mu_done_r) nr_r <= sat32(rnd_shr(mul_res, 14));
      ST_MD: if (mu_done_r) nm_r <= sat32(rnd_shr(mul_res, 14));
      ST_HD: if (dv_done_r) begin
        na_r <= hq;
        da_r <= 33'(hq) - 33'(hd_r);
      end
      ST_DA: if (da_r == 33'sd0) begin
        lx_r <= 34'(dm);
        ly_r <= 34'(dmean);
      end
      ST_CR: if (dv_done_r) begin
        cx_r   <= GAIN_Q30;
        cy_r   <= '0;
        cz_r   <= z0;
        flip_r <= fl0;
        ci_r   <= '0;
      end
      ST_CI: begin
        cx_r <= cx_nxt;
        cy_r <= cy_nxt;
        cz_r <= cz_nxt;
        ci_r <= ci_r + 1'b1;
        if (ci_r == CI_LAST) begin
          if (ph_r) begin
            sa_r <= cs_out;
            ca_r <= cc_out;
          end else begin
            s1_r <= cs_out;
          end
        end
      end
      ST_SC: if (dv_done_r) sc_r <= scq;
      ST_LX1, ST_LY1, ST_RX1, ST_RY1: if (mu_done_r) acc_r <= mul_res;
      ST_LX2: if (mu_done_r) lx_r <= clamp_off(rnd_shr(acc_r + mul_res, 30));
      ST_LY2: if (mu_done_r) ly_r <= clamp_off(rnd_shr(acc_r + mul_res, 30));
      default: ;
    endcase
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_pose_x_out  = ox_r;
  assign out_pose_y_out  = oy_r;
  assign out_heading_out = oh_r;

endmodule

`default_nettype wire

// File: src/twao_checker.sv
// Port-level checks for three_wheel_arc_odometry and the bind that attaches them.
// Depends on the top level's port names.
`default_nettype none

module twao_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_pose_x_out,
  input logic signed [31:0] out_pose_y_out,
  input logic signed [31:0] out_heading_out
);

  // An accepted sample keeps the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken right after a transfer");

  // Reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A result appears only at the end of a busy stretch
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without work");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pose_x_out) &&
      $stable(out_pose_y_out) && $stable(out_heading_out))
    else $error("stalled result changed");

endmodule

bind three_wheel_arc_odometry twao_checker u_twao_checker (.*);

`default_nettype wire
